// File: design/lag_pkg.sv
// Package: shared constants, types and control structs of the Life generation block.
`default_nettype none

package lag_pkg;

  localparam int unsigned LAG_MAX_SIDE  = 32;
  localparam int unsigned LAG_MIN_SIDE  = 3;
  localparam int unsigned CFG_W         = 6;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned COUNT_W       = 4;
  localparam int unsigned BIRTH_COUNT   = 3;
  localparam int unsigned SURVIVE_COUNT = 2;

  // Per-item sequencing: own cell, row-end cell, last-row flush.
  typedef enum logic [2:0] {
    ST_CELL  = 3'b001,
    ST_EDGE  = 3'b010,
    ST_FLUSH = 3'b100
  } lag_step_e;

  typedef struct packed {
    logic write;
    logic rotate;
    logic clear;
  } lag_store_cmd_t;

endpackage

`default_nettype wire

// File: design/lag_if.sv
// Interfaces: cell input, result output and configuration write channels.
`default_nettype none

interface lag_cell_if import lag_pkg::*; ();
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

interface lag_result_if import lag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             next_alive;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             run_last;
  logic             frame_end;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output run_last, output frame_end, input ready);
  modport sink (input valid, input next_alive, input out_row, input out_col,
                input run_last, input frame_end, output ready);
endinterface

interface lag_cfg_if import lag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] side_length;

  modport source (output valid, output side_length, input ready);
  modport sink (input valid, input side_length, output ready);
endinterface

`default_nettype wire

// File: design/life_automaton_generation.sv
// Top level: streamed one-generation Life engine with input and result registers.
//
//  channel   dir  payload                                          transaction
//  cell_i    in   cell_alive                                       valid & ready
//  result_o  out  next_alive, out_row, out_col, run_last, frame_end  valid & ready
//  cfg_i     in   side_length                                      valid & ready
//
// One cell per cycle unless the result stalls; a row end adds an edge step, the frame end a flush.
// Each cycle of an item emits at most one transaction into the result register.
// Reset: side MAX_SIDE, counters and row stores cleared; a config write restarts the frame.
// A stalled result register holds the step that needs it; the input register
// still holds that item and takes no new cell meanwhile.
`default_nettype none

module life_automaton_generation import lag_pkg::*; #(
  parameter int unsigned MAX_SIDE = LAG_MAX_SIDE
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  lag_cell_if.sink   cell_i,
  lag_cfg_if.sink    cfg_i,
  lag_result_if.source result_o
);

  localparam int unsigned COL_W = $clog2(MAX_SIDE);

  logic             in_valid_q, in_valid_d;
  logic             in_cell_q;
  logic [COL_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] flush_col_q, flush_col_d;
  logic [COL_W-1:0] side_m1_q, side_m1_d;
  lag_step_e        step_q, step_d;

  logic             out_valid_q;
  logic             out_alive_q;
  logic [POS_W-1:0] out_row_q, out_col_q;
  logic             out_run_last_q, out_frame_end_q;

  logic                in_accept, cfg_accept;
  logic                last_col, last_row, has_up;
  logic                emit_req, emit_run_last, emit_frame_end;
  logic [COL_W-1:0]    eval_col, emit_row;
  logic                use_lower_eff;
  logic                out_free, step_go, item_done;
  logic                eval_alive;
  logic [CFG_W-1:0]    side_clamped;
  lag_store_cmd_t      store_cmd;
  logic [MAX_SIDE-1:0] upper, middle, lower, lower_eff, lower_sel;

  assign in_accept  = cell_i.valid && cell_i.ready;
  assign cfg_accept = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  assign last_col = (col_q == side_m1_q);
  assign last_row = (row_q == side_m1_q);
  assign has_up   = (row_q != '0);

  assign lower_eff = lower | (MAX_SIDE'(in_cell_q) << col_q);
  assign lower_sel = use_lower_eff ? lower_eff : lower;

  always_comb begin
    emit_req       = 1'b0;
    emit_run_last  = 1'b0;
    emit_frame_end = 1'b0;
    eval_col       = flush_col_q;
    emit_row       = row_q;
    use_lower_eff  = 1'b0;
    case (step_q)
      ST_CELL: begin
        emit_req      = has_up && (col_q != '0);
        emit_run_last = !last_col;
        eval_col      = col_q - COL_W'(1);
        emit_row      = row_q - COL_W'(1);
        use_lower_eff = 1'b1;
      end
      ST_EDGE: begin
        emit_req      = has_up;
        emit_run_last = !last_row;
        eval_col      = side_m1_q;
        emit_row      = row_q - COL_W'(1);
      end
      ST_FLUSH: begin
        emit_req       = 1'b1;
        emit_run_last  = (flush_col_q == side_m1_q);
        emit_frame_end = (flush_col_q == side_m1_q);
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_q || result_o.ready;
  assign step_go  = in_valid_q && (!emit_req || out_free);

  always_comb begin
    step_d      = step_q;
    row_d       = row_q;
    col_d       = col_q;
    flush_col_d = flush_col_q;
    item_done   = 1'b0;
    store_cmd   = '0;
    if (cfg_accept) begin
      step_d          = ST_CELL;
      row_d           = '0;
      col_d           = '0;
      flush_col_d     = '0;
      store_cmd.clear = 1'b1;
    end else if (step_go) begin
      case (step_q)
        ST_CELL: begin
          store_cmd.write = 1'b1;
          if (last_col) begin
            step_d = ST_EDGE;
          end else begin
            col_d     = col_q + COL_W'(1);
            item_done = 1'b1;
          end
        end
        ST_EDGE: begin
          store_cmd.rotate = 1'b1;
          if (last_row) begin
            step_d      = ST_FLUSH;
            flush_col_d = '0;
          end else begin
            step_d    = ST_CELL;
            row_d     = row_q + COL_W'(1);
            col_d     = '0;
            item_done = 1'b1;
          end
        end
        ST_FLUSH: begin
          if (flush_col_q == side_m1_q) begin
            step_d          = ST_CELL;
            row_d           = '0;
            col_d           = '0;
            store_cmd.clear = 1'b1;
            item_done       = 1'b1;
          end else begin
            flush_col_d = flush_col_q + COL_W'(1);
          end
        end
        default: begin
          step_d = ST_CELL;
        end
      endcase
    end
  end

  assign cell_i.ready = !in_valid_q || item_done;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (item_done) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    side_clamped = cfg_i.side_length;
    if (cfg_i.side_length < CFG_W'(LAG_MIN_SIDE)) begin
      side_clamped = CFG_W'(LAG_MIN_SIDE);
    end else if (cfg_i.side_length > CFG_W'(MAX_SIDE)) begin
      side_clamped = CFG_W'(MAX_SIDE);
    end
    side_m1_d = cfg_accept ? COL_W'(side_clamped - CFG_W'(1)) : side_m1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      step_q      <= ST_CELL;
      row_q       <= '0;
      col_q       <= '0;
      flush_col_q <= '0;
      side_m1_q   <= COL_W'(MAX_SIDE - 1);
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      step_q      <= step_d;
      row_q       <= row_d;
      col_q       <= col_d;
      flush_col_q <= flush_col_d;
      side_m1_q   <= side_m1_d;
      if (step_go && emit_req) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_cell_q <= cell_i.cell_alive;
    end
    if (step_go && emit_req) begin
      out_alive_q     <= eval_alive;
      out_row_q       <= POS_W'(emit_row);
      out_col_q       <= POS_W'(eval_col);
      out_run_last_q  <= emit_run_last;
      out_frame_end_q <= emit_frame_end;
    end
  end

  lag_line_store #(
    .MAX_SIDE (MAX_SIDE)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (store_cmd),
    .wr_col_i (col_q),
    .wr_bit_i (in_cell_q),
    .upper_o  (upper),
    .middle_o (middle),
    .lower_o  (lower)
  );

  lag_cell_eval #(
    .MAX_SIDE (MAX_SIDE)
  ) u_eval (
    .upper_i  (upper),
    .middle_i (middle),
    .lower_i  (lower_sel),
    .col_i    (eval_col),
    .alive_o  (eval_alive)
  );

  assign result_o.valid      = out_valid_q;
  assign result_o.next_alive = out_alive_q;
  assign result_o.out_row    = out_row_q;
  assign result_o.out_col    = out_col_q;
  assign result_o.run_last   = out_run_last_q;
  assign result_o.frame_end  = out_frame_end_q;

`ifndef SYNTH
  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= side_m1_q) && (col_q <= side_m1_q) && (flush_col_q <= side_m1_q))
    else $error("position counter beyond grid side");

  a_flush_on_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_FLUSH) |-> (last_row && last_col))
    else $error("row flush outside the frame's last cell");

  a_step_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_CELL) |-> in_valid_q)
    else $error("row-end step without a held cell");

  a_frame_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_frame_end_q) |-> out_run_last_q)
    else $error("frame end result not marked as last of its transaction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> (out_valid_q && $stable(out_row_q)
      && $stable(out_col_q)))
    else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

// File: design/lag_line_store.sv
// Three row line stores: upper, middle and the row being filled.
`default_nettype none

module lag_line_store import lag_pkg::*; #(
  parameter int unsigned MAX_SIDE = LAG_MAX_SIDE,
  localparam int unsigned COL_W = $clog2(MAX_SIDE)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lag_store_cmd_t      cmd_i,
  input  wire logic [COL_W-1:0]    wr_col_i,
  input  wire logic                wr_bit_i,
  output logic      [MAX_SIDE-1:0] upper_o,
  output logic      [MAX_SIDE-1:0] middle_o,
  output logic      [MAX_SIDE-1:0] lower_o
);

  logic [MAX_SIDE-1:0] upper_q, middle_q, lower_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      middle_q <= '0;
      lower_q  <= '0;
    end else if (cmd_i.clear) begin
      upper_q  <= '0;
      middle_q <= '0;
      lower_q  <= '0;
    end else if (cmd_i.rotate) begin
      upper_q  <= middle_q;
      middle_q <= lower_q;
      lower_q  <= '0;
    end else if (cmd_i.write) begin
      lower_q[wr_col_i] <= wr_bit_i;
    end
  end

  assign upper_o  = upper_q;
  assign middle_o = middle_q;
  assign lower_o  = lower_q;

endmodule

`default_nettype wire

// File: design/lag_cell_eval.sv
// Neighborhood count and Life rule for one column of the middle row.
`default_nettype none

module lag_cell_eval import lag_pkg::*; #(
  parameter int unsigned MAX_SIDE = LAG_MAX_SIDE,
  localparam int unsigned COL_W = $clog2(MAX_SIDE),
  localparam int unsigned PAD_W = $clog2(MAX_SIDE + 2)
) (
  input  wire logic [MAX_SIDE-1:0] upper_i,
  input  wire logic [MAX_SIDE-1:0] middle_i,
  input  wire logic [MAX_SIDE-1:0] lower_i,
  input  wire logic [COL_W-1:0]    col_i,
  output logic                     alive_o
);

  logic [MAX_SIDE+1:0] up_pad, mid_pad, low_pad;
  logic [PAD_W-1:0]    base;
  logic [2:0]          up_w, mid_w, low_w;
  logic [COUNT_W-1:0]  n;

  // Zero pad on both sides: cells off the grid are dead.
  assign up_pad  = {1'b0, upper_i, 1'b0};
  assign mid_pad = {1'b0, middle_i, 1'b0};
  assign low_pad = {1'b0, lower_i, 1'b0};
  assign base    = PAD_W'(col_i);

  assign up_w  = up_pad[base +: 3];
  assign mid_w = mid_pad[base +: 3];
  assign low_w = low_pad[base +: 3];

  assign n = COUNT_W'(up_w[0]) + COUNT_W'(up_w[1]) + COUNT_W'(up_w[2])
           + COUNT_W'(mid_w[0]) + COUNT_W'(mid_w[2])
           + COUNT_W'(low_w[0]) + COUNT_W'(low_w[1]) + COUNT_W'(low_w[2]);

  assign alive_o = (n == COUNT_W'(BIRTH_COUNT))
                || (mid_w[1] && (n == COUNT_W'(SURVIVE_COUNT)));

endmodule

`default_nettype wire
